// ===== src/fpp_pkg.sv =====
// ----------------------------------------------------------------------------
// fpp_pkg
// shared types, constants and helpers of the fifo page pool
// ----------------------------------------------------------------------------
package fpp_pkg;

  localparam int POOL_DEPTH = 16;
  localparam int IDX_W      = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
  localparam int CNT_W      = $clog2(POOL_DEPTH + 1);
  localparam int CAP_W      = 5;
  localparam int CMP_W      = (CAP_W > CNT_W) ? CAP_W : CNT_W;
  localparam int OBJ_W      = 16;
  localparam int PAGE_W     = 16;
  localparam int FUNC_W     = 2;
  localparam int RCNT_W     = 5;
  localparam int MISS_W     = 32;
  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(2);

  typedef enum logic [FUNC_W-1:0] {
    FN_ACCESS = 2'd0,
    FN_DELETE = 2'd1,
    FN_EMPTY  = 2'd2
  } func_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic              mat;
    logic [OBJ_W-1:0]  obj;
    logic [PAGE_W-1:0] x;
    logic [PAGE_W-1:0] y;
  } pool_key_t;

  typedef struct packed {
    logic              hit;
    logic              evicted;
    pool_key_t         evk;
    logic [RCNT_W-1:0] removed_count;
    logic [RCNT_W-1:0] occupancy;
    logic [MISS_W-1:0] matrix_misses;
  } result_t;

  typedef struct packed {
    logic start;
    logic scan;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic scan_done;
    logic out_free;
  } status_t;

  function automatic logic [IDX_W-1:0] ring_add(input logic [IDX_W-1:0] base,
                                                input logic [CNT_W-1:0] off);
    logic [CNT_W:0] s;
    s = (CNT_W+1)'(base) + (CNT_W+1)'(off);
    if (s >= (CNT_W+1)'(POOL_DEPTH)) begin
      s = s - (CNT_W+1)'(POOL_DEPTH);
    end
    return s[IDX_W-1:0];
  endfunction

endpackage

// ===== src/fpp_in_if.sv =====
// ----------------------------------------------------------------------------
// fpp_in_if
// command channel of the fifo page pool
// ----------------------------------------------------------------------------
interface fpp_in_if;
  logic                        valid;
  logic                        ready;
  logic [fpp_pkg::FUNC_W-1:0]  func;
  logic                        is_matrix;
  logic [fpp_pkg::OBJ_W-1:0]   object_id;
  logic [fpp_pkg::PAGE_W-1:0]  page_x;
  logic [fpp_pkg::PAGE_W-1:0]  page_y;

  modport source (output valid, func, is_matrix, object_id, page_x, page_y,
                  input ready);
  modport sink   (input valid, func, is_matrix, object_id, page_x, page_y,
                  output ready);
endinterface

// ===== src/fpp_out_if.sv =====
// ----------------------------------------------------------------------------
// fpp_out_if
// result channel of the fifo page pool
// ----------------------------------------------------------------------------
interface fpp_out_if;
  logic                        valid;
  logic                        ready;
  logic                        hit;
  logic                        evicted;
  logic                        evict_is_matrix;
  logic [fpp_pkg::OBJ_W-1:0]   evict_object;
  logic [fpp_pkg::PAGE_W-1:0]  evict_x;
  logic [fpp_pkg::PAGE_W-1:0]  evict_y;
  logic [fpp_pkg::RCNT_W-1:0]  removed_count;
  logic [fpp_pkg::RCNT_W-1:0]  occupancy;
  logic [fpp_pkg::MISS_W-1:0]  matrix_misses;

  modport source (output valid, hit, evicted, evict_is_matrix, evict_object, evict_x,
                  evict_y, removed_count, occupancy, matrix_misses, input ready);
  modport sink   (input valid, hit, evicted, evict_is_matrix, evict_object, evict_x,
                  evict_y, removed_count, occupancy, matrix_misses, output ready);
endinterface

// ===== src/fpp_ctrl.sv =====
// ----------------------------------------------------------------------------
// fpp_ctrl
// controller: sequences accept, key scan and result commit
// ----------------------------------------------------------------------------
module fpp_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  fpp_pkg::status_t status,
  output fpp_pkg::cmd_t    cmd
);

  fpp_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= fpp_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    cmd       = '0;
    case (state_r)
      fpp_pkg::ST_IDLE: begin
        in_ready  = 1'b1;
        cmd.start = in_valid;
        if (in_valid) begin
          state_nxt = fpp_pkg::ST_SCAN;
        end
      end
      fpp_pkg::ST_SCAN: begin
        cmd.scan = 1'b1;
        if (status.scan_done) begin
          state_nxt = fpp_pkg::ST_FINISH;
        end
      end
      fpp_pkg::ST_FINISH: begin
        if (status.out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = fpp_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = fpp_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ===== src/fpp_dp.sv =====
// ----------------------------------------------------------------------------
// fpp_dp
// datapath: ring-ordered key memory, scan and compaction, counters, result
// ----------------------------------------------------------------------------
module fpp_dp (
  input  logic                        clk,
  input  logic                        rst_n,
  input  fpp_pkg::cmd_t               cmd,
  output fpp_pkg::status_t            status,
  input  logic [fpp_pkg::FUNC_W-1:0]  in_func,
  input  fpp_pkg::pool_key_t          in_key,
  input  logic                        cfg_we,
  input  logic [fpp_pkg::CAP_W-1:0]   cfg_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output fpp_pkg::result_t            out_res
);

  fpp_pkg::pool_key_t mem [fpp_pkg::POOL_DEPTH];

  logic [fpp_pkg::FUNC_W-1:0] func_r;
  fpp_pkg::pool_key_t         key_r;
  fpp_pkg::pool_key_t         rdata_r;
  fpp_pkg::pool_key_t         evk_r;
  logic [fpp_pkg::IDX_W-1:0]  head_r;
  logic [fpp_pkg::CNT_W-1:0]  count_r;
  logic [fpp_pkg::CNT_W-1:0]  rd_off_r;
  logic [fpp_pkg::CNT_W-1:0]  pend_off_r;
  logic [fpp_pkg::CNT_W-1:0]  w_r;
  logic                       pend_r;
  logic                       hit_r;
  logic [fpp_pkg::MISS_W-1:0] miss_r;
  logic [fpp_pkg::CAP_W-1:0]  cap_r;
  logic                       out_valid_r;
  fpp_pkg::result_t           res_r;

  logic                       is_access, is_delete, needs_scan, issue;
  logic [fpp_pkg::IDX_W-1:0]  rd_addr;
  logic                       wr_en;
  logic [fpp_pkg::IDX_W-1:0]  wr_addr;
  fpp_pkg::pool_key_t         wr_data;
  logic [fpp_pkg::CMP_W-1:0]  eff_cap;
  logic                       miss, evict, append;
  logic [fpp_pkg::CNT_W-1:0]  count_nxt;
  logic [fpp_pkg::CNT_W-1:0]  removed;
  logic [fpp_pkg::MISS_W-1:0] miss_nxt;
  logic                       keep;

  assign is_access  = (func_r == fpp_pkg::FN_ACCESS);
  assign is_delete  = (func_r == fpp_pkg::FN_DELETE);
  assign needs_scan = is_access || is_delete;
  assign issue      = cmd.scan && needs_scan && (rd_off_r < count_r);
  assign rd_addr    = fpp_pkg::ring_add(head_r, rd_off_r);
  assign keep       = rdata_r.obj != key_r.obj;

  assign status.scan_done = !needs_scan || ((rd_off_r == count_r) && !pend_r);
  assign status.out_free  = !out_valid_r || out_ready;

  // effective capacity: zero acts as one, clipped to the pool depth
  always_comb begin
    eff_cap = fpp_pkg::CMP_W'(cap_r);
    if (cap_r == '0) begin
      eff_cap = fpp_pkg::CMP_W'(1);
    end else if (eff_cap > fpp_pkg::CMP_W'(fpp_pkg::POOL_DEPTH)) begin
      eff_cap = fpp_pkg::CMP_W'(fpp_pkg::POOL_DEPTH);
    end
  end

  always_comb begin
    miss      = is_access && !hit_r;
    evict     = miss && (fpp_pkg::CMP_W'(count_r) >= eff_cap) && (count_r != '0);
    count_nxt = count_r - fpp_pkg::CNT_W'(evict);
    append    = miss && (count_nxt < fpp_pkg::CNT_W'(fpp_pkg::POOL_DEPTH));
    removed   = '0;
    miss_nxt  = miss_r + fpp_pkg::MISS_W'(miss && key_r.mat);
    case (func_r)
      fpp_pkg::FN_ACCESS: begin
        count_nxt = count_nxt + fpp_pkg::CNT_W'(append);
      end
      fpp_pkg::FN_DELETE: begin
        count_nxt = w_r;
        removed   = count_r - w_r;
      end
      fpp_pkg::FN_EMPTY: begin
        count_nxt = '0;
        removed   = count_r;
      end
      default: begin
        count_nxt = count_r;
      end
    endcase
  end

  // memory write: compaction during delete, append at commit
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = fpp_pkg::ring_add(head_r, w_r);
    wr_data = rdata_r;
    if (pend_r && is_delete && keep) begin
      wr_en = 1'b1;
    end else if (cmd.commit && append) begin
      wr_en   = 1'b1;
      wr_addr = fpp_pkg::ring_add(head_r, count_r);
      wr_data = key_r;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (issue) begin
      rdata_r <= mem[rd_addr];
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      func_r <= in_func;
      key_r  <= in_key;
    end
    if (issue) begin
      pend_off_r <= rd_off_r;
    end
    if (pend_r && is_access && (pend_off_r == '0)) begin
      evk_r <= rdata_r;
    end
    if (cmd.commit) begin
      res_r.hit           <= is_access && hit_r;
      res_r.evicted       <= evict;
      res_r.evk           <= evict ? evk_r : '0;
      res_r.removed_count <= fpp_pkg::RCNT_W'(removed);
      res_r.occupancy     <= fpp_pkg::RCNT_W'(count_nxt);
      res_r.matrix_misses <= miss_nxt;
    end
  end

  // control and architectural state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      count_r     <= '0;
      miss_r      <= '0;
      cap_r       <= fpp_pkg::CAP_RESET;
      rd_off_r    <= '0;
      w_r         <= '0;
      pend_r      <= 1'b0;
      hit_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        cap_r <= cfg_data;
      end
      pend_r <= issue;
      if (cmd.start) begin
        rd_off_r <= '0;
        w_r      <= '0;
        hit_r    <= 1'b0;
      end else begin
        if (issue) begin
          rd_off_r <= rd_off_r + fpp_pkg::CNT_W'(1);
        end
        if (pend_r && is_access && (rdata_r == key_r)) begin
          hit_r <= 1'b1;
        end
        if (pend_r && is_delete && keep) begin
          w_r <= w_r + fpp_pkg::CNT_W'(1);
        end
      end
      if (cmd.commit) begin
        count_r <= count_nxt;
        miss_r  <= miss_nxt;
        if (evict) begin
          head_r <= fpp_pkg::ring_add(head_r, fpp_pkg::CNT_W'(1));
        end
      end
      if (cmd.commit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = res_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= fpp_pkg::CNT_W'(fpp_pkg::POOL_DEPTH))
    else $error("pool occupancy beyond depth");

  a_compact_order: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> (w_r <= pend_off_r))
    else $error("compaction write index passed read index");

  a_commit_shows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> out_valid_r)
    else $error("committed result not presented");

  a_scan_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (issue || pend_r) |-> !cmd.commit)
    else $error("commit during key scan");

endmodule

// ===== src/fifo_page_pool.sv =====
// ----------------------------------------------------------------------------
// fifo_page_pool
// fully associative page pool with first-in, first-out replacement
//
//   port       dir   kind                 beat / write
//   in_chan    in    valid/ready channel  one command: access, delete, empty
//   out_chan   out   valid/ready channel  one result per command
//   cfg_*      in    write enable, data   capacity register
//
// an access or delete scans every stored key before its commit; the key memory has
// a single read port, one entry per cycle
// empty and unused commands skip the scan
// a new command is taken while the previous result waits in the output register;
// its commit then stalls until that register is free
// reset empties the pool, zeroes the miss count and sets capacity to 2; the key
// memory is not cleared
// ----------------------------------------------------------------------------
module fifo_page_pool (
  input  logic                       clk,
  input  logic                       rst_n,
  fpp_in_if.sink                     in_chan,
  fpp_out_if.source                  out_chan,
  input  logic                       cfg_wr_en,
  input  logic [fpp_pkg::CAP_W-1:0]  cfg_wr_data
);

  fpp_pkg::cmd_t      cmd;
  fpp_pkg::status_t   status;
  fpp_pkg::pool_key_t in_key;
  fpp_pkg::result_t   res;

  // table pages keep a zero second index
  assign in_key.mat = in_chan.is_matrix;
  assign in_key.obj = in_chan.object_id;
  assign in_key.x   = in_chan.page_x;
  assign in_key.y   = in_chan.is_matrix ? in_chan.page_y : '0;

  fpp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_chan.ready),
    .status   (status),
    .cmd      (cmd)
  );

  fpp_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .status    (status),
    .in_func   (in_chan.func),
    .in_key    (in_key),
    .cfg_we    (cfg_wr_en),
    .cfg_data  (cfg_wr_data),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .out_res   (res)
  );

  assign out_chan.hit             = res.hit;
  assign out_chan.evicted         = res.evicted;
  assign out_chan.evict_is_matrix = res.evk.mat;
  assign out_chan.evict_object    = res.evk.obj;
  assign out_chan.evict_x         = res.evk.x;
  assign out_chan.evict_y         = res.evk.y;
  assign out_chan.removed_count   = res.removed_count;
  assign out_chan.occupancy       = res.occupancy;
  assign out_chan.matrix_misses   = res.matrix_misses;

endmodule

// ===== bench/fifo_page_pool_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// fifo_page_pool_test
// drives command beats into the page pool under random gaps and stalls,
// tracks the expected pool contents, eviction order and matrix miss count
// in a local model, and checks every result beat field by field; capacity
// is rewritten between phases while the pool is idle
// ----------------------------------------------------------------------------
module fifo_page_pool_test;

  localparam logic [fpp_pkg::FUNC_W-1:0] FN_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int BEATS_PER_PHASE = 156;

  typedef struct packed {
    logic [fpp_pkg::FUNC_W-1:0] fn;
    fpp_pkg::pool_key_t         key;
  } pool_cmd_t;

  logic                      clk;
  logic                      rst_n;
  logic                      cfg_wr_en;
  logic [fpp_pkg::CAP_W-1:0] cfg_wr_data;

  fpp_in_if  in_chan ();
  fpp_out_if out_chan ();

  fifo_page_pool dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_chan     (in_chan),
    .out_chan    (out_chan),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  pool_cmd_t           cmd_backlog[$];
  fpp_pkg::result_t    pool_outcomes[$];
  fpp_pkg::pool_key_t  pool_ent[fpp_pkg::POOL_DEPTH];
  int         pool_fill = 0;
  logic [fpp_pkg::MISS_W-1:0] miss_total = '0;
  logic [fpp_pkg::CAP_W-1:0]  cap_reg = fpp_pkg::CAP_RESET;
  int         err_count = 0;
  int         cycle_cnt = 0;
  logic       in_fire = 1'b0;
  logic       out_fire = 1'b0;
  int         send_gap = 0;
  int         send_calm = 0;
  int         recv_stall = 0;
  int         recv_calm = 0;
  logic [fpp_pkg::OBJ_W-1:0] hot_obj[4] = '{16'h0000, 16'hFFFF, 16'h1234, 16'h00A5};
  logic [fpp_pkg::CAP_W-1:0] caps[9];

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic int pick_gap(ref int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 4) begin
      calm = $urandom_range(20, 60);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic void drop_entry(input int idx);
    for (int i = idx; i + 1 < pool_fill; i++) begin
      pool_ent[i] = pool_ent[i + 1];
    end
    pool_fill--;
  endfunction

  // advances the pool model by one command and returns its result beat
  function automatic fpp_pkg::result_t pool_apply(input logic [fpp_pkg::FUNC_W-1:0] fn,
                                                  input fpp_pkg::pool_key_t raw);
    fpp_pkg::result_t   r;
    fpp_pkg::pool_key_t k;
    int        lim;
    int        i;
    logic      found;
    r = '0;
    k = raw;
    if (!k.mat) k.y = '0;
    found = 1'b0;
    case (fn)
      fpp_pkg::FN_ACCESS: begin
        for (i = 0; i < pool_fill; i++) begin
          if (pool_ent[i] == k) found = 1'b1;
        end
        if (found) begin
          r.hit = 1'b1;
        end else begin
          if (k.mat) miss_total = miss_total + 1'b1;
          lim = (cap_reg == 0) ? 1 :
                ((cap_reg > fpp_pkg::POOL_DEPTH) ? fpp_pkg::POOL_DEPTH : int'(cap_reg));
          if (pool_fill >= lim && pool_fill > 0) begin
            r.evicted = 1'b1;
            r.evk = pool_ent[0];
            drop_entry(0);
          end
          if (pool_fill < fpp_pkg::POOL_DEPTH) begin
            pool_ent[pool_fill] = k;
            pool_fill++;
          end
        end
      end
      fpp_pkg::FN_DELETE: begin
        i = 0;
        while (i < pool_fill) begin
          if (pool_ent[i].obj == k.obj) begin
            drop_entry(i);
            r.removed_count++;
          end else begin
            i++;
          end
        end
      end
      fpp_pkg::FN_EMPTY: begin
        r.removed_count = fpp_pkg::RCNT_W'(pool_fill);
        pool_fill = 0;
      end
      default: begin
      end
    endcase
    r.occupancy = fpp_pkg::RCNT_W'(pool_fill);
    r.matrix_misses = miss_total;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      err_count++;
    end
  endtask

  task automatic check_beat();
    fpp_pkg::result_t want;
    if (pool_outcomes.size() == 0) begin
      $display("%0t: unexpected result beat, expected none, actual occupancy %0d",
               $time, out_chan.occupancy);
      err_count++;
    end else begin
      want = pool_outcomes[0];
      pool_outcomes.delete(0);
      check_field("hit", want.hit, out_chan.hit);
      check_field("evicted", want.evicted, out_chan.evicted);
      check_field("evict_is_matrix", want.evk.mat, out_chan.evict_is_matrix);
      check_field("evict_object", want.evk.obj, out_chan.evict_object);
      check_field("evict_x", want.evk.x, out_chan.evict_x);
      check_field("evict_y", want.evk.y, out_chan.evict_y);
      check_field("removed_count", want.removed_count, out_chan.removed_count);
      check_field("occupancy", want.occupancy, out_chan.occupancy);
      check_field("matrix_misses", want.matrix_misses, out_chan.matrix_misses);
    end
  endtask

  // sample side
  always @(posedge clk) begin
    fpp_pkg::pool_key_t k;
    cycle_cnt++;
    in_fire <= rst_n && in_chan.valid && in_chan.ready;
    out_fire <= rst_n && out_chan.valid && out_chan.ready;
    if (rst_n) begin
      if (cfg_wr_en) cap_reg = cfg_wr_data;
      if (out_chan.valid && out_chan.ready) check_beat();
      if (in_chan.valid && in_chan.ready) begin
        k.mat = in_chan.is_matrix;
        k.obj = in_chan.object_id;
        k.x = in_chan.page_x;
        k.y = in_chan.page_y;
        pool_outcomes.insert(pool_outcomes.size(), pool_apply(in_chan.func, k));
      end
    end
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("fifo_page_pool_test: done, errors");
      $finish;
    end
  end

  // command driver
  always @(negedge clk) begin
    pool_cmd_t c;
    if (!rst_n) begin
      in_chan.valid <= 1'b0;
    end else if (!in_chan.valid || in_fire) begin
      if (send_gap > 0) begin
        send_gap--;
        in_chan.valid <= 1'b0;
      end else if (cmd_backlog.size() > 0) begin
        c = cmd_backlog[0];
        cmd_backlog.delete(0);
        in_chan.func <= c.fn;
        in_chan.is_matrix <= c.key.mat;
        in_chan.object_id <= c.key.obj;
        in_chan.page_x <= c.key.x;
        in_chan.page_y <= c.key.y;
        in_chan.valid <= 1'b1;
        send_gap = pick_gap(send_calm);
      end else begin
        in_chan.valid <= 1'b0;
      end
    end
  end

  // result receiver
  always @(negedge clk) begin
    if (out_fire) recv_stall = pick_gap(recv_calm);
    if (recv_stall > 0) begin
      recv_stall--;
      out_chan.ready <= 1'b0;
    end else begin
      out_chan.ready <= 1'b1;
    end
  end

  function automatic void queue_cmd(input logic [fpp_pkg::FUNC_W-1:0] fn, input logic mat,
                                    input logic [fpp_pkg::OBJ_W-1:0] obj,
                                    input logic [fpp_pkg::PAGE_W-1:0] x,
                                    input logic [fpp_pkg::PAGE_W-1:0] y);
    pool_cmd_t c;
    c.fn = fn;
    c.key.mat = mat;
    c.key.obj = obj;
    c.key.x = x;
    c.key.y = y;
    cmd_backlog.insert(cmd_backlog.size(), c);
  endfunction

  function automatic logic [fpp_pkg::OBJ_W-1:0] pick_obj();
    if ($urandom_range(0, 9) == 0) return fpp_pkg::OBJ_W'($urandom);
    return hot_obj[$urandom_range(0, 3)];
  endfunction

  function automatic void queue_random_cmd();
    int r;
    logic [fpp_pkg::PAGE_W-1:0] x;
    logic [fpp_pkg::PAGE_W-1:0] y;
    logic                       mat;
    r = $urandom_range(0, 99);
    mat = 1'($urandom_range(0, 1));
    if ($urandom_range(0, 9) == 0) begin
      x = fpp_pkg::PAGE_W'($urandom);
      y = fpp_pkg::PAGE_W'($urandom);
    end else begin
      x = fpp_pkg::PAGE_W'($urandom_range(0, 3));
      y = fpp_pkg::PAGE_W'($urandom_range(0, 1));
    end
    if (r < 90) queue_cmd(fpp_pkg::FN_ACCESS, mat, pick_obj(), x, y);
    else if (r < 95) queue_cmd(fpp_pkg::FN_DELETE, mat, pick_obj(), x, y);
    else if (r < 97) queue_cmd(fpp_pkg::FN_EMPTY, mat, fpp_pkg::OBJ_W'($urandom), x, y);
    else queue_cmd(FN_UNUSED, mat, fpp_pkg::OBJ_W'($urandom), x, y);
  endfunction

  task automatic wait_drained();
    while (cmd_backlog.size() != 0 || in_chan.valid || pool_outcomes.size() != 0) begin
      @(posedge clk);
    end
    repeat (4) @(negedge clk);
  endtask

  task automatic set_capacity(input logic [fpp_pkg::CAP_W-1:0] v);
    wait_drained();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  initial begin
    caps = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd5, 5'd17, 5'd3, 5'd16, 5'd8};
    rst_n = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    in_chan.valid = 1'b0;
    in_chan.func = fpp_pkg::FN_ACCESS;
    in_chan.is_matrix = 1'b0;
    in_chan.object_id = '0;
    in_chan.page_x = '0;
    in_chan.page_y = '0;
    out_chan.ready = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed, capacity at its reset value
    queue_cmd(fpp_pkg::FN_ACCESS, 1'b0, 16'h0000, 16'h0000, 16'h0000);
    queue_cmd(fpp_pkg::FN_ACCESS, 1'b0, 16'h0000, 16'h0000, 16'hFFFF);
    queue_cmd(fpp_pkg::FN_ACCESS, 1'b1, 16'h0000, 16'h0000, 16'h0000);
    queue_cmd(fpp_pkg::FN_ACCESS, 1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    queue_cmd(fpp_pkg::FN_ACCESS, 1'b1, 16'h0000, 16'h0000, 16'h0000);
    queue_cmd(fpp_pkg::FN_ACCESS, 1'b0, 16'hFFFF, 16'hFFFF, 16'h0000);
    queue_cmd(fpp_pkg::FN_DELETE, 1'b0, 16'hFFFF, 16'h1234, 16'h4321);
    queue_cmd(FN_UNUSED, 1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    queue_cmd(fpp_pkg::FN_ACCESS, 1'b0, 16'h8000, 16'h0001, 16'h0000);
    queue_cmd(fpp_pkg::FN_EMPTY, 1'b0, 16'h0000, 16'h0000, 16'h0000);
    queue_cmd(fpp_pkg::FN_EMPTY, 1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    queue_cmd(fpp_pkg::FN_DELETE, 1'b1, 16'h0000, 16'h0000, 16'h0000);
    queue_cmd(fpp_pkg::FN_ACCESS, 1'b0, 16'h5555, 16'hAAAA, 16'h5555);
    queue_cmd(fpp_pkg::FN_ACCESS, 1'b1, 16'hAAAA, 16'h5555, 16'hAAAA);
    queue_cmd(fpp_pkg::FN_ACCESS, 1'b0, 16'h5555, 16'hAAAA, 16'hAAAA);
    queue_cmd(fpp_pkg::FN_DELETE, 1'b0, 16'hAAAA, 16'h0000, 16'h0000);

    foreach (caps[p]) begin
      set_capacity(caps[p]);
      repeat (BEATS_PER_PHASE) queue_random_cmd();
    end

    wait_drained();
    repeat (40) @(posedge clk);
    if (err_count == 0) begin
      $display("fifo_page_pool_test: done, clean");
    end else begin
      $display("fifo_page_pool_test: done, errors");
    end
    $finish;
  end

endmodule
